>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a boolean at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/olid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olid_pkg
// Types and constants of the ordered list with insert and delete.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int MAX_CAPACITY   = 1024;

  // Field widths of the words on the channels
  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int DIN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int RDATA_W  = 32;
  localparam int ECOUNT_W = 7;

  // Index width wide enough for any supported capacity
  localparam int IDX_MAX_W = $clog2(MAX_CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [DIN_W-1:0] data_in;
  } olid_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RDATA_W-1:0]  read_data;
    logic [ECOUNT_W-1:0] entry_count;
  } olid_out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                 load;
    logic                 shift_up;
    logic                 shift_down;
    logic [IDX_MAX_W-1:0] pos;
    logic [IDX_MAX_W-1:0] wr_pos;
  } olid_ctl_t;

endpackage
`default_nettype wire

>>> rtl/olid_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olid_cell
// One list entry: loads a new word, takes its left or right neighbor.
// ----------------------------------------------------------------------------
module olid_cell
  import olid_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire olid_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] q_o,
  output logic      [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IDX_MAX_W-1:0] Idx = IDX_MAX_W'(INDEX);

  logic [DATA_WIDTH-1:0] entry_q;
  logic [DATA_WIDTH-1:0] entry_d;

  // Pick the next value: new word, left neighbor on insert, right on delete
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load && (Idx == ctl_i.wr_pos)) begin
      entry_d = word_i;
    end else if (ctl_i.shift_up && (Idx > ctl_i.pos)) begin
      entry_d = left_i;
    end else if (ctl_i.shift_down && (Idx >= ctl_i.pos)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  // Drive the entry onto the read bus only when addressed
  assign rd_o = (Idx == ctl_i.pos) ? entry_q : '0;

endmodule
`default_nettype wire

>>> rtl/olid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olid_ctrl
// Command decode, range and full checks, and the entry count register.
// ----------------------------------------------------------------------------
module olid_ctrl
  import olid_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire logic [POS_W-1:0] pos_i,
  output olid_ctl_t             ctl_o,
  output status_e               status_o,
  output logic                  rd_en_o,
  output logic      [CntW-1:0]  count_o,
  output logic      [CntW-1:0]  count_next_o
);

  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] cnt_x;
  logic            full;
  logic            load;
  logic            shift_up;
  logic            shift_down;
  logic            inc;
  logic            dec;
  logic            at_end;

  assign pos_x = CmpW'(pos_i);
  assign cnt_x = CmpW'(count_q);
  assign full  = (count_q == CntW'(CAPACITY));

  // Decode the command and check index and capacity
  always_comb begin
    status_o   = ST_OK;
    load       = 1'b0;
    shift_up   = 1'b0;
    shift_down = 1'b0;
    inc        = 1'b0;
    dec        = 1'b0;
    rd_en_o    = 1'b0;
    at_end     = 1'b0;
    case (cmd_i)
      CMD_APPEND: begin
        at_end = 1'b1;
        if (full) begin
          status_o = ST_FULL;
        end else begin
          load = 1'b1;
          inc  = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          load     = 1'b1;
          shift_up = 1'b1;
          inc      = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else begin
          shift_down = 1'b1;
          dec        = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else begin
          load = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else begin
          rd_en_o = 1'b1;
        end
      end
      default: begin
        status_o = ST_OK;
      end
    endcase
  end

  // Compute the count after this command
  always_comb begin
    count_d = count_q;
    if (inc) begin
      count_d = count_q + CntW'(1);
    end else if (dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Advance the count only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  // Broadcast to the cells; enables only on an accepted word
  assign ctl_o.load       = fire_i & load;
  assign ctl_o.shift_up   = fire_i & shift_up;
  assign ctl_o.shift_down = fire_i & shift_down;
  assign ctl_o.pos        = IDX_MAX_W'(pos_i);
  assign ctl_o.wr_pos     = at_end ? IDX_MAX_W'(count_q) : IDX_MAX_W'(pos_i);

  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule
`default_nettype wire

>>> rtl/ordered_list_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Fixed-capacity ordered list held in a row of shifting register cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command word (append, insert, delete,
//   update, read) with a position and a data word. The output channel
//   returns one word per command: status, read data and the entry count
//   after the command.
//   Every cell decides on its own whether to keep its entry, load the new
//   word, or take the entry of its left (insert) or right (delete)
//   neighbor, so every command finishes in the cycle it is accepted.
//   The result is registered in the output register on acceptance;
//   throughput is one command per cycle while the receiver keeps up, set
//   by the single output register that parts the two channels.
//   When the receiver stalls, the result holds in the output register and
//   one more command is not taken until it drains.
//   Reset clears the entry count and the output valid; the cell contents
//   are not cleared and are only ever read after being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire olid_in_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output olid_out_t      out_word_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic                  fire;
  olid_ctl_t             ctl;
  status_e               status;
  logic                  rd_en;
  logic [CntW-1:0]       count;
  logic [CntW-1:0]       count_next;
  logic [63:0]           din_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_or;
  logic [63:0]           rd_ext;
  logic [15:0]           cnt_ext;
  olid_out_t             res;
  olid_out_t             out_q;
  logic                  out_valid_q;

  // Take a new word whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Mask the incoming data word to the entry width
  assign din_ext = 64'(in_word_i.data_in);
  assign word    = din_ext[DATA_WIDTH-1:0];

  olid_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (in_word_i.cmd),
    .pos_i        (in_word_i.position),
    .ctl_o        (ctl),
    .status_o     (status),
    .rd_en_o      (rd_en),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // Row of cells; the ends see zero beyond the row
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (gi == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_q[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_q[gi+1];
    end
    olid_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[gi]),
      .rd_o    (cell_rd[gi])
    );
  end

  // Combine the gated read outputs of all cells
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign rd_ext  = 64'(rd_or);
  assign cnt_ext = 16'(count_next);

  // Assemble the result word
  always_comb begin
    res.status      = status;
    res.read_data   = rd_en ? rd_ext[RDATA_W-1:0] : '0;
    res.entry_count = cnt_ext[ECOUNT_W-1:0];
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count <= CntW'(CAPACITY))
  `ASSERT_IMPLY(a_err_keeps_count, clk_i, rst_ni, fire && (status != ST_OK),
                count_next == count)
  `ASSERT_NEXT(a_err_no_data, clk_i, rst_ni, fire && (status != ST_OK),
               out_valid_q && (out_q.read_data == '0))

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shifting ordered list: a queue-fed driver
// offers command words, a shadow list predicts every result word, and a
// monitor compares status, read data and entry count as words drain.
// ----------------------------------------------------------------------------
module tb_top;
  import olid_pkg::*;

  localparam int          CAPACITY   = DEF_CAPACITY;
  localparam int          DATA_WIDTH = DEF_DATA_WIDTH;
  localparam logic [31:0] DATA_MASK  = 32'((64'h1 << DATA_WIDTH) - 1);
  localparam int          LONG_HOLD  = 200;
  localparam int          MAX_SHOWN  = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  olid_in_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  olid_out_t out_word_o;

  // Shadow copy of the list contents and length
  logic [31:0] list_words [CAPACITY];
  int          list_len;

  olid_in_t  cmd_q [$];
  olid_out_t result_q [$];
  int        plan_len;
  int        src_gap;
  int        sink_gap;
  bit        src_idle_en;
  bit        sink_idle_en;
  bit        long_hold;
  int        fault_cnt;

  ordered_list_insert_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the result word
  function automatic olid_out_t apply_list_cmd(olid_in_t w);
    olid_out_t   r;
    logic [31:0] word;
    int          p;
    r = '0;
    r.status = ST_OK;
    word = w.data_in & DATA_MASK;
    p = int'(w.position);
    case (w.cmd)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (p > list_len) begin
          r.status = ST_BAD_INDEX;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = word;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_UPDATE: begin
        if (p >= list_len) r.status = ST_BAD_INDEX;
        else list_words[p] = word;
      end
      CMD_READ: begin
        if (p >= list_len) r.status = ST_BAD_INDEX;
        else r.read_data = list_words[p];
      end
      default: ;
    endcase
    r.entry_count = ECOUNT_W'(list_len);
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queue one command and track the length it leaves behind
  task automatic queue_cmd(logic [CMD_W-1:0] cmd, int pos, logic [DIN_W-1:0] data);
    olid_in_t w;
    w.cmd = cmd;
    w.position = POS_W'(pos);
    w.data_in = data;
    cmd_q.push_back(w);
    case (cmd)
      CMD_APPEND: if (plan_len < CAPACITY) plan_len++;
      CMD_INSERT: if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
      CMD_DELETE: if (pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  // Queue random commands; grow and shrink weights steer the list length
  task automatic queue_random(int n, int grow_pct, int shrink_pct);
    int               r;
    int               pos;
    logic [CMD_W-1:0] cmd;
    logic [DIN_W-1:0] data;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) cmd = CMD_W'($urandom_range(CMD_READ + 1, (1 << CMD_W) - 1));
      else if (r < 3 + grow_pct) cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
      else if (r < 3 + grow_pct + shrink_pct) cmd = CMD_DELETE;
      else cmd = $urandom_range(1) ? CMD_UPDATE : CMD_READ;
      if ($urandom_range(9) < 8) begin
        if (cmd == CMD_INSERT) pos = $urandom_range(0, plan_len);
        else pos = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
        if (pos > (1 << POS_W) - 1) pos = (1 << POS_W) - 1;
      end else begin
        pos = $urandom_range(0, (1 << POS_W) - 1);
      end
      r = $urandom_range(9);
      if (r == 0) data = '0;
      else if (r == 1) data = '1;
      else data = $urandom;
      queue_cmd(cmd, pos, data);
    end
  endtask

  // Hold until every queued word has gone in and every result has come out
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid_i || result_q.size() != 0) @(negedge clk_i);
  endtask

  // Compare one result word with the oldest prediction
  task automatic check_list_word(olid_out_t got);
    olid_out_t want;
    if (result_q.size() == 0) begin
      fault_cnt++;
      if (fault_cnt <= MAX_SHOWN)
        $display("%0t: unexpected result word status=%0d data=%h count=%0d",
                 $realtime, got.status, got.read_data, got.entry_count);
      return;
    end
    want = result_q.pop_front();
    if (got.status !== want.status || got.read_data !== want.read_data ||
        got.entry_count !== want.entry_count) begin
      fault_cnt++;
      if (fault_cnt <= MAX_SHOWN)
        $display("%0t: mismatch status exp %0d got %0d, data exp %h got %h, count exp %0d got %0d",
                 $realtime, want.status, got.status, want.read_data, got.read_data,
                 want.entry_count, got.entry_count);
    end
  endtask

  // Driver: predict on acceptance, hold a stalled word, else load the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      src_gap    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) result_q.push_back(apply_list_cmd(in_word_i));
      if (!(in_valid_i && !in_ready_o)) begin
        gap = src_gap;
        if (in_valid_i) gap = src_idle_en ? idle_len() : 0;
        if (gap == 0 && cmd_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_word_i  <= cmd_q.pop_front();
          src_gap    <= 0;
        end else begin
          in_valid_i <= 1'b0;
          src_gap    <= (gap == 0) ? 0 : gap - 1;
        end
      end
    end
  end

  // Monitor: check accepted results, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) check_list_word(out_word_o);
      if (long_hold) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap != 0) begin
        out_ready_i <= 1'b0;
        sink_gap    <= sink_gap - 1;
      end else begin
        gap = sink_idle_en ? idle_len() : 0;
        out_ready_i <= (gap == 0);
        sink_gap    <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // Stimulus phases
  initial begin
    list_len     = 0;
    plan_len     = 0;
    fault_cnt    = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    long_hold    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty list, edges of insert, reads, deletes, spare commands
    queue_cmd(CMD_READ,   0, 32'h0000_0001);
    queue_cmd(CMD_DELETE, 0, 32'h0);
    queue_cmd(CMD_UPDATE, 0, 32'hDEAD_BEEF);
    queue_cmd(CMD_INSERT, 1, 32'h1111_1111);
    queue_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);
    queue_cmd(CMD_APPEND, 0, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 2, 32'h1234_5678);
    queue_cmd(CMD_INSERT, 1, 32'hA5A5_A5A5);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_READ, i, 32'h0);
    queue_cmd(CMD_READ,   4, 32'h0);
    queue_cmd(CMD_READ,   63, 32'hFFFF_FFFF);
    queue_cmd(CMD_UPDATE, 3, 32'h5A5A_5A5A);
    queue_cmd(CMD_DELETE, 1, 32'h0);
    queue_cmd(CMD_DELETE, 2, 32'h0);
    for (int c = CMD_READ + 1; c < (1 << CMD_W); c++)
      queue_cmd(CMD_W'(c), 63, 32'hFFFF_FFFF);
    queue_cmd(CMD_READ,   0, 32'h0);
    queue_cmd(CMD_READ,   1, 32'h0);
    queue_cmd(CMD_DELETE, 0, 32'h0);
    queue_cmd(CMD_DELETE, 0, 32'h0);
    queue_cmd(CMD_APPEND, 0, 32'h8000_0001);
    wait_drained();

    // Fill to full with no idling, under a long receiver stall
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    fork
      begin
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        @(negedge clk_i);
        long_hold = 1'b0;
      end
    join_none
    queue_random(150, 70, 10);
    wait_drained();

    // Churn around the middle with idling on both sides
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    queue_random(200, 35, 35);
    wait_drained();

    // Drain to empty
    queue_random(120, 10, 70);
    wait_drained();

    // Refill with only the sender idling, then churn with only the receiver idling
    sink_idle_en = 1'b0;
    queue_random(150, 70, 10);
    wait_drained();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    queue_random(60, 30, 30);
    wait_drained();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (result_q.size() != 0) fault_cnt++;
    if (fault_cnt == 0) begin
      $display("PASS ordered_list_insert_delete");
    end else begin
      $display("FAIL ordered_list_insert_delete");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL ordered_list_insert_delete");
    $finish;
  end

endmodule
